// File: sv/phcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phcr_pkg: shared constants and types
// Widths and fixed-point formats of the pixel to hex cube rounding block.
// ----------------------------------------------------------------------------
package phcr_pkg;

  localparam int IN_W        = 24;   // signed Q15.8 pixel position
  localparam int SIZE_W      = 16;   // unsigned Q8.8 hex size
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 16;

  localparam int SQRT3_W = 31;
  localparam logic [SQRT3_W-1:0] SQRT3_Q30 = 31'd1859775393;
  localparam int Q30 = 30;

  // numerator sqrt3*x - y*2^30 and 2*y*2^30, signed
  localparam int NUM_W = IN_W + 32;
  localparam int MAG_W = NUM_W - 1;

  // divisor 3*size << (30 - FRAC_BITS)
  localparam int DEN_SHIFT = Q30 - FRAC_BITS;
  localparam int DEN_W     = SIZE_W + 2 + DEN_SHIFT;
  localparam logic [DEN_W-1:0] DEN_RESET = DEN_W'(768) << DEN_SHIFT;

  // quotient magnitude bound: |num| < 2^MAG_W, den >= 2^(31-FRAC_BITS)
  localparam int QUO_W = IN_W + FRAC_BITS;
  localparam int CMP_W = DEN_W + QUO_W;

  localparam int FW     = QUO_W + 3;          // signed fraction q, r, s
  localparam int AM_W   = FW - 1;             // fraction magnitude
  localparam int RM_W   = FW - FRAC_BITS;     // rounded magnitude
  localparam int RND_W  = RM_W + 1;           // signed rounded value
  localparam int BLD_W  = RND_W + 1;          // rebuilt coordinate
  localparam int ERR_W  = FRAC_BITS + 1;      // rounding error
  localparam int DIFF_W = FRAC_BITS + 2;

  localparam logic [AM_W-1:0] HALF = AM_W'(1) << (FRAC_BITS - 1);

  localparam int CHK_W = ((BLD_W > COORD_WIDTH) ? BLD_W : COORD_WIDTH) + 1;
  localparam logic signed [CHK_W-1:0] CMIN = -(CHK_W'(1) <<< (COORD_WIDTH - 1));
  localparam logic signed [CHK_W-1:0] CMAX = (CHK_W'(1) <<< (COORD_WIDTH - 1)) - 1;

  localparam int IN_DATA_W  = ((2 * IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_q;
    logic signed [NUM_W-1:0] num_r;
  } div_req_t;

  typedef struct packed {
    logic             neg_q;
    logic             neg_r;
    logic [QUO_W-1:0] quo_q;
    logic [QUO_W-1:0] quo_r;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/phcr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phcr_divider: pipelined dual restoring divider
// Divides the magnitudes of two signed numerators by one shared divisor,
// one quotient bit per stage, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module phcr_divider
  import phcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [DEN_W-1:0] den,
  input  logic             in_valid,
  output logic             in_ready,
  input  div_req_t         in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output div_rsp_t         out_rsp
);

  logic             vld   [QUO_W+1];
  logic             ld    [QUO_W+1];
  logic [MAG_W-1:0] rem_q [QUO_W+1];
  logic [MAG_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [QUO_W-1:0] quo_r [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic             neg_r [QUO_W+1];

  logic [NUM_W-1:0] abs_q;
  logic [NUM_W-1:0] abs_r;

  logic             ent_v;
  logic [MAG_W-1:0] ent_rq;
  logic [MAG_W-1:0] ent_rr;
  logic             ent_nq;
  logic             ent_nr;

  assign abs_q = in_req.num_q[NUM_W-1] ? NUM_W'(-in_req.num_q) : NUM_W'(in_req.num_q);
  assign abs_r = in_req.num_r[NUM_W-1] ? NUM_W'(-in_req.num_r) : NUM_W'(in_req.num_r);

  for (genvar k = 0; k <= QUO_W; k++) begin : g_ld
    if (k == QUO_W) begin : g_last
      assign ld[k] = !vld[k] || out_ready;
    end else begin : g_mid
      assign ld[k] = !vld[k] || ld[k+1];
    end
  end

  // stage 0: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_v <= 1'b0;
    end else if (ld[0]) begin
      ent_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ent_rq <= abs_q[MAG_W-1:0];
      ent_rr <= abs_r[MAG_W-1:0];
      ent_nq <= in_req.num_q[NUM_W-1];
      ent_nr <= in_req.num_r[NUM_W-1];
    end
  end

  assign vld[0]   = ent_v;
  assign rem_q[0] = ent_rq;
  assign rem_r[0] = ent_rr;
  assign quo_q[0] = '0;
  assign quo_r[0] = '0;
  assign neg_q[0] = ent_nq;
  assign neg_r[0] = ent_nr;

  // stage k resolves quotient bit QUO_W-k
  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    localparam int Bit = QUO_W - k;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] ext_q;
    logic [CMP_W-1:0] ext_r;
    logic             fit_q;
    logic             fit_r;
    logic             v;
    logic [MAG_W-1:0] rq;
    logic [MAG_W-1:0] rr;
    logic [QUO_W-1:0] qq;
    logic [QUO_W-1:0] qr;
    logic             nq;
    logic             nr;

    assign dsh   = CMP_W'(den) << Bit;
    assign ext_q = CMP_W'(rem_q[k-1]);
    assign ext_r = CMP_W'(rem_r[k-1]);
    assign fit_q = ext_q >= dsh;
    assign fit_r = ext_r >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (ld[k]) begin
        v <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rq <= fit_q ? MAG_W'(ext_q - dsh) : rem_q[k-1];
        rr <= fit_r ? MAG_W'(ext_r - dsh) : rem_r[k-1];
        qq <= {quo_q[k-1][QUO_W-2:0], fit_q};
        qr <= {quo_r[k-1][QUO_W-2:0], fit_r};
        nq <= neg_q[k-1];
        nr <= neg_r[k-1];
      end
    end

    assign vld[k]   = v;
    assign rem_q[k] = rq;
    assign rem_r[k] = rr;
    assign quo_q[k] = qq;
    assign quo_r[k] = qr;
    assign neg_q[k] = nq;
    assign neg_r[k] = nr;
  end

  assign in_ready      = ld[0];
  assign out_valid     = vld[QUO_W];
  assign out_rsp.neg_q = neg_q[QUO_W];
  assign out_rsp.neg_r = neg_r[QUO_W];
  assign out_rsp.quo_q = quo_q[QUO_W];
  assign out_rsp.quo_r = quo_r[QUO_W];

endmodule
`default_nettype wire

// File: sv/pixel_to_hex_cube_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_to_hex_cube_round: pixel position to pointy-top hex cube coordinates
// Fractional q, r from a pipelined divide by 3*size, s = -q-r, rounding
// half away from zero, rebuild of the worst-rounded coordinate, range check.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata (pixel_x, pixel_y).
//   Each produces exactly one item on m_tvalid/m_tready/m_tdata
//   (cube_q, cube_r, cube_s) with the overflow flag on m_tuser.
//   hex_size is written on cfg_valid/cfg_ready/cfg_data, by the user only
//   while no items are in flight (the block does not enforce it); cfg_ready
//   is always high. A size of zero yields zero coordinates with overflow set.
//   Items pass P1, P2, the bit-per-stage divider (an input stage plus one
//   stage per quotient bit) and R1 to R7. Throughput is one item per cycle
//   while the receiver does not stall the output with m_tready low.
//   Every stage has its own valid bit and advances when empty or when the
//   stage after it moves, so a stalled receiver holds the result in the
//   output register while bubbles further up still fill; s_tready drops
//   only once every stage holds an item.
//   Reset (rst, synchronous) empties the pipeline and sets hex_size to 1.0.
// ----------------------------------------------------------------------------
module pixel_to_hex_cube_round
  import phcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel_x, pixel_y
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // cube_q, cube_r, cube_s
  output logic                  m_tuser,   // overflow
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SIZE_W-1:0]     cfg_data   // hex_size
);

  function automatic logic [ERR_W-1:0] round_err(logic [RM_W-1:0] m, logic [AM_W-1:0] a);
    logic signed [DIFF_W-1:0] d;
    d = $signed((DIFF_W'(m) << FRAC_BITS) - DIFF_W'(a));
    return d[DIFF_W-1] ? ERR_W'(-d) : ERR_W'(d);
  endfunction

  function automatic logic in_range(logic signed [BLD_W-1:0] v);
    return (CHK_W'(v) >= CMIN) && (CHK_W'(v) <= CMAX);
  endfunction

  // configuration
  logic [DEN_W-1:0] den;
  logic             size_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      den       <= DEN_RESET;
      size_zero <= 1'b0;
    end else if (cfg_valid) begin
      den       <= DEN_W'((SIZE_W + 2)'(cfg_data) + ((SIZE_W + 2)'(cfg_data) << 1)) << DEN_SHIFT;
      size_zero <= cfg_data == '0;
    end
  end

  // stage handshake
  logic     vp1, vp2;
  logic     ldp1, ldp2;
  logic     div_in_ready, div_out_valid;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     v1, v2, v3, v4, v5, v6, v7;
  logic     ld1, ld2, ld3, ld4, ld5, ld6, ld7;

  assign ld7  = !v7 || m_tready;
  assign ld6  = !v6 || ld7;
  assign ld5  = !v5 || ld6;
  assign ld4  = !v4 || ld5;
  assign ld3  = !v3 || ld4;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;
  assign ldp2 = !vp2 || div_in_ready;
  assign ldp1 = !vp1 || ldp2;
  assign s_tready = ldp1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
      vp2 <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
    end else begin
      if (ldp1) vp1 <= s_tvalid;
      if (ldp2) vp2 <= vp1;
      if (ld1) v1 <= div_out_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) v6 <= v5;
      if (ld7) v7 <= v6;
    end
  end

  // P1: sqrt3 * x
  logic signed [NUM_W-1:0] prod;
  logic signed [IN_W-1:0]  y1;

  always_ff @(posedge clk) begin
    if (ldp1) begin
      prod <= NUM_W'($signed({1'b0, SQRT3_Q30})) * NUM_W'($signed(s_tdata[IN_W-1:0]));
      y1   <= $signed(s_tdata[2*IN_W-1:IN_W]);
    end
  end

  // P2: numerators
  logic signed [NUM_W-1:0] num_q, num_r;

  always_ff @(posedge clk) begin
    if (ldp2) begin
      num_q <= prod - (NUM_W'(y1) <<< Q30);
      num_r <= NUM_W'(y1) <<< (Q30 + 1);
    end
  end

  assign div_req.num_q = num_q;
  assign div_req.num_r = num_r;

  phcr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .den       (den),
    .in_valid  (vp2),
    .in_ready  (div_in_ready),
    .in_req    (div_req),
    .out_valid (div_out_valid),
    .out_ready (ld1),
    .out_rsp   (div_rsp)
  );

  // R1: signed fractions
  logic signed [FW-1:0] fq1, fr1;

  always_ff @(posedge clk) begin
    if (ld1) begin
      fq1 <= div_rsp.neg_q ? -$signed(FW'(div_rsp.quo_q)) : $signed(FW'(div_rsp.quo_q));
      fr1 <= div_rsp.neg_r ? -$signed(FW'(div_rsp.quo_r)) : $signed(FW'(div_rsp.quo_r));
    end
  end

  // R2: s fraction
  logic signed [FW-1:0] fq2, fr2, fs2;

  always_ff @(posedge clk) begin
    if (ld2) begin
      fq2 <= fq1;
      fr2 <= fr1;
      fs2 <= -fq1 - fr1;
    end
  end

  // R3: magnitudes
  logic [AM_W-1:0] aq3, ar3, as3;
  logic            nq3, nr3, ns3;

  always_ff @(posedge clk) begin
    if (ld3) begin
      aq3 <= fq2[FW-1] ? AM_W'(-fq2) : AM_W'(fq2);
      ar3 <= fr2[FW-1] ? AM_W'(-fr2) : AM_W'(fr2);
      as3 <= fs2[FW-1] ? AM_W'(-fs2) : AM_W'(fs2);
      nq3 <= fq2[FW-1];
      nr3 <= fr2[FW-1];
      ns3 <= fs2[FW-1];
    end
  end

  // R4: rounded magnitudes
  logic [RM_W-1:0] mq4, mr4, ms4;
  logic [AM_W-1:0] aq4, ar4, as4;
  logic            nq4, nr4, ns4;
  logic [AM_W:0]   sq4, sr4, ss4;

  assign sq4 = (AM_W + 1)'(aq3) + (AM_W + 1)'(HALF);
  assign sr4 = (AM_W + 1)'(ar3) + (AM_W + 1)'(HALF);
  assign ss4 = (AM_W + 1)'(as3) + (AM_W + 1)'(HALF);

  always_ff @(posedge clk) begin
    if (ld4) begin
      mq4 <= sq4[AM_W:FRAC_BITS];
      mr4 <= sr4[AM_W:FRAC_BITS];
      ms4 <= ss4[AM_W:FRAC_BITS];
      aq4 <= aq3;
      ar4 <= ar3;
      as4 <= as3;
      nq4 <= nq3;
      nr4 <= nr3;
      ns4 <= ns3;
    end
  end

  // R5: signed rounded values and rounding errors
  logic signed [RND_W-1:0] rq5, rr5, rs5;
  logic [ERR_W-1:0]        eq5, er5, es5;

  always_ff @(posedge clk) begin
    if (ld5) begin
      rq5 <= nq4 ? -$signed(RND_W'(mq4)) : $signed(RND_W'(mq4));
      rr5 <= nr4 ? -$signed(RND_W'(mr4)) : $signed(RND_W'(mr4));
      rs5 <= ns4 ? -$signed(RND_W'(ms4)) : $signed(RND_W'(ms4));
      eq5 <= round_err(mq4, aq4);
      er5 <= round_err(mr4, ar4);
      es5 <= round_err(ms4, as4);
    end
  end

  // R6: rebuild the coordinate with the largest error
  logic signed [BLD_W-1:0] q6, r6, s6;
  logic signed [BLD_W-1:0] q5x, r5x, s5x;

  assign q5x = BLD_W'(rq5);
  assign r5x = BLD_W'(rr5);
  assign s5x = BLD_W'(rs5);

  always_ff @(posedge clk) begin
    if (ld6) begin
      if (eq5 > er5 && eq5 > es5) begin
        q6 <= -r5x - s5x;
        r6 <= r5x;
        s6 <= s5x;
      end else if (er5 > es5) begin
        q6 <= q5x;
        r6 <= -q5x - s5x;
        s6 <= s5x;
      end else begin
        q6 <= q5x;
        r6 <= r5x;
        s6 <= -q5x - r5x;
      end
    end
  end

  // R7: range check, output register
  logic                   ovf6;
  logic [COORD_WIDTH-1:0] out_q, out_r, out_s;
  logic                   out_ovf;

  assign ovf6 = size_zero || !in_range(q6) || !in_range(r6) || !in_range(s6);

  always_ff @(posedge clk) begin
    if (ld7) begin
      out_q   <= ovf6 ? '0 : COORD_WIDTH'(q6);
      out_r   <= ovf6 ? '0 : COORD_WIDTH'(r6);
      out_s   <= ovf6 ? '0 : COORD_WIDTH'(s6);
      out_ovf <= ovf6;
    end
  end

  assign m_tvalid = v7;
  assign m_tdata  = OUT_DATA_W'({out_s, out_r, out_q});
  assign m_tuser  = out_ovf;

`ifndef NO_ASSERTIONS
  a_ovf_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (out_q == '0 && out_r == '0 && out_s == '0))
    else $error("overflow result with nonzero coordinates");

  a_cube_sum : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> COORD_WIDTH'(out_q + out_r + out_s) == '0)
    else $error("cube coordinates do not sum to zero");

  a_zero_size : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && size_zero |-> m_tuser)
    else $error("zero hex size without overflow");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (vp1 && vp2 && v1 && v2 && v3 && v4 && v5 && v6 && v7))
    else $error("input stalled with an empty stage");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: pixel to hex cube rounding, self-checking stream test
// Drives pixel positions under several hex sizes, including zero and both
// extremes. Each accepted item is run through a local predictor of the hex
// lookup, and every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import phcr_pkg::*;

  localparam longint ROOT3_Q30   = 1859775393;  // sqrt(3), unsigned Q2.30
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     DRAIN_WAIT  = 64;
  localparam int     N_PHASES    = 9;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] q;
    logic signed [COORD_WIDTH-1:0] r;
    logic signed [COORD_WIDTH-1:0] s;
    logic                          ovf;
  } hex_cell_t;

  class cube_cell_board;
    logic [SIZE_W-1:0] hex_size;
    hex_cell_t         pending_cells[$];
    int unsigned       checked;
    int unsigned       errors;
    int unsigned       overflows;

    function new();
      hex_size  = 16'd256;
      checked   = 0;
      errors    = 0;
      overflows = 0;
    endfunction

    function longint round_away(longint v);
      longint mag;
      longint rnd;
      mag = (v < 0) ? -v : v;
      rnd = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (v < 0) ? -rnd : rnd;
    endfunction

    function longint round_err(longint rounded, longint v);
      longint d;
      d = rounded * (longint'(1) << FRAC_BITS) - v;
      return (d < 0) ? -d : d;
    endfunction

    function hex_cell_t locate_cell(logic signed [IN_W-1:0] px, logic signed [IN_W-1:0] py);
      longint    x, y, den, ynum, fq, fr, fs, q, r, s, eq, er, es, lo, hi;
      logic      ovf;
      hex_cell_t hit;
      x   = px;
      y   = py;
      lo  = -(longint'(1) << (COORD_WIDTH - 1));
      hi  = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      q   = 0;
      r   = 0;
      s   = 0;
      ovf = 1'b0;
      if (hex_size == '0) begin
        ovf = 1'b1;
      end else begin
        den  = longint'(hex_size) * 3 * (longint'(1) << (30 - FRAC_BITS));
        ynum = y * (longint'(1) << 30);
        fq   = (ROOT3_Q30 * x - ynum) / den;
        fr   = (2 * ynum) / den;
        fs   = -fq - fr;
        q    = round_away(fq);
        r    = round_away(fr);
        s    = round_away(fs);
        eq   = round_err(q, fq);
        er   = round_err(r, fr);
        es   = round_err(s, fs);
        // worst-rounded coordinate is rebuilt; ties fall toward s, a q-r tie toward r
        if (eq > er && eq > es) begin
          q = -r - s;
        end else if (er > es) begin
          r = -q - s;
        end else begin
          s = -q - r;
        end
        if (q < lo || q > hi || r < lo || r > hi || s < lo || s > hi) begin
          ovf = 1'b1;
        end
      end
      if (ovf) begin
        q = 0;
        r = 0;
        s = 0;
      end
      hit.q   = q[COORD_WIDTH-1:0];
      hit.r   = r[COORD_WIDTH-1:0];
      hit.s   = s[COORD_WIDTH-1:0];
      hit.ovf = ovf;
      return hit;
    endfunction

    function void note_pixel(logic signed [IN_W-1:0] px, logic signed [IN_W-1:0] py);
      pending_cells.insert(pending_cells.size(), locate_cell(px, py));
    endfunction

    function void check_cell(logic [OUT_DATA_W-1:0] data, logic flag);
      hex_cell_t want;
      hex_cell_t got;
      logic      bad;
      got.q   = data[0 +: COORD_WIDTH];
      got.r   = data[COORD_WIDTH +: COORD_WIDTH];
      got.s   = data[2*COORD_WIDTH +: COORD_WIDTH];
      got.ovf = flag;
      if (pending_cells.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: q=%0d r=%0d s=%0d ovf=%0b",
                   got.q, got.r, got.s, got.ovf);
        end
        return;
      end
      want = pending_cells.pop_front();
      checked++;
      if (got.ovf === 1'b1) overflows++;
      bad = (got.q !== want.q) || (got.r !== want.r) || (got.s !== want.s) ||
            (got.ovf !== want.ovf);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on result %0d: expected q=%0d r=%0d s=%0d ovf=%0b, ",
                   checked, want.q, want.r, want.s, want.ovf,
                   "got q=%0d r=%0d s=%0d ovf=%0b",
                   got.q, got.r, got.s, got.ovf);
        end
      end
    endfunction

    function int pending();
      return pending_cells.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // pixel_x, pixel_y
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // cube_q, cube_r, cube_s
  logic                  m_tuser;          // overflow
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SIZE_W-1:0]     cfg_data  = '0;   // hex_size

  cube_cell_board board = new();

  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned sizes_used    = 1;

  pixel_to_hex_cube_round dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_count, board.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_cell(m_tdata, m_tuser);
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pixel(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    board.note_pixel(x, y);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic retune(input logic [SIZE_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.hex_size = v;
    sizes_used++;
  endtask

  function automatic logic signed [IN_W-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0:       return {1'b0, {(IN_W-1){1'b1}}};
      1:       return {1'b1, {(IN_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return IN_W'(1);
    endcase
  endfunction

  task automatic pick_pixel(input logic [SIZE_W-1:0] size,
                            output logic signed [IN_W-1:0] x,
                            output logic signed [IN_W-1:0] y);
    int unsigned kind;
    int          span;
    kind = $urandom_range(0, 99);
    span = (size == '0) ? 4096 : int'(size) * 48;
    if (span > 8388607) span = 8388607;
    if (kind < 15) begin
      x = IN_W'($urandom);
      y = IN_W'($urandom);
    end else if (kind < 45) begin
      x = IN_W'(int'($urandom_range(0, 8192)) - 4096);
      y = IN_W'(int'($urandom_range(0, 8192)) - 4096);
    end else if (kind < 80) begin
      x = IN_W'(int'($urandom_range(0, 2 * span)) - span);
      y = IN_W'(int'($urandom_range(0, 2 * span)) - span);
    end else if (kind < 92) begin
      // grid-aligned points hit exact halves and error ties
      x = ($urandom_range(0, 2) == 0) ? '0 : IN_W'((int'($urandom_range(0, 256)) - 128) * 64);
      y = ($urandom_range(0, 2) == 0) ? '0 : IN_W'((int'($urandom_range(0, 256)) - 128) * 64);
    end else begin
      x = extreme_coord();
      y = extreme_coord();
    end
  endtask

  initial begin
    logic [SIZE_W-1:0]       sizes [N_PHASES];
    logic signed [IN_W-1:0]  px, py;
    int                      n_items;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset size 1.0
    send_pixel(24'sd0, 24'sd0);
    send_pixel(24'sd0, 24'sd192);
    send_pixel(24'sd0, -24'sd192);
    send_pixel(24'sd0, 24'sd384);
    send_pixel(24'sd221, 24'sd0);
    send_pixel(24'sd222, 24'sd0);
    send_pixel(24'sh7FFFFF, 24'sh7FFFFF);
    send_pixel(24'sh800000, 24'sh800000);
    send_pixel(24'sh7FFFFF, 24'sh800000);
    send_pixel(24'sh800000, 24'sh7FFFFF);
    send_pixel(-24'sd1, -24'sd1);
    send_pixel(24'sd1, 24'sd1);
    send_pixel(24'sd443, -24'sd256);
    // smallest size: coordinates run out of range
    retune(16'd1);
    send_pixel(24'sh7FFFFF, 24'sd0);
    send_pixel(24'sd0, 24'sd0);
    send_pixel(24'sh800000, 24'sd0);
    send_pixel(24'sd256, -24'sd256);
    // zero size
    retune(16'd0);
    send_pixel(24'sd0, 24'sd0);
    send_pixel(24'sh7FFFFF, 24'sh800000);
    send_pixel(24'sd12345, -24'sd6789);
    // largest size
    retune(16'hFFFF);
    send_pixel(24'sh7FFFFF, 24'sh7FFFFF);
    send_pixel(24'sh800000, 24'sh800000);
    send_pixel(24'sd100000, -24'sd50000);

    sizes[0] = 16'hFFFF;
    sizes[1] = 16'd1;
    sizes[2] = 16'd0;
    sizes[3] = SIZE_W'($urandom_range(1, 65535));
    sizes[4] = 16'd256;
    sizes[5] = SIZE_W'($urandom_range(1, 8));
    sizes[6] = SIZE_W'($urandom_range(9, 1024));
    sizes[7] = SIZE_W'($urandom_range(1025, 65534));
    sizes[8] = SIZE_W'($urandom_range(1, 65535));

    for (int p = 0; p < N_PHASES; p++) begin
      retune(sizes[p]);
      if (p < 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 54;
      end else if (p < 6) begin
        send_idle_pct = 54;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n_items = (sizes[p] == '0) ? 30 : 190;
      for (int i = 0; i < n_items; i++) begin
        // hold off mid-phase until the pipeline has emptied
        if (p == 4 && i == n_items / 2) drain();
        pick_pixel(sizes[p], px, py);
        send_pixel(px, py);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d pixel items under %0d hex size settings ",
             items_sent, sizes_used, "(zero, 1/256 and max among them)");
    $display("%0d results compared, %0d flagged overflow, %0d errors",
             board.checked, board.overflows, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: pixel_to_hex_cube_round.f
sv/phcr_pkg.sv
sv/phcr_divider.sv
sv/pixel_to_hex_cube_round.sv
verif/testbench.sv
